// File: design/cchu_pkg.sv
// Types, constants and the CRC-16/CCITT-FALSE byte update for the command frame handler.
`timescale 1ns / 1ps

package cchu_pkg;

	// Frame and response layout
	localparam logic [7:0] CMD_SET_TARGET = 8'h20;
	localparam logic [7:0] CMD_SOURCE     = 8'h80;
	localparam logic [7:0] ARG_LAUNCH     = 8'hAA;
	localparam logic [7:0] ARG_SHUTDOWN   = 8'hBB;
	localparam logic [7:0] RSP_HEADER     = 8'h80;
	localparam logic [7:0] STATUS_RUNNING = 8'hAA;
	localparam logic [7:0] STATUS_STOPPED = 8'hBB;
	localparam int         MIN_FRAME      = 4;

	// CRC-16/CCITT-FALSE
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	// Configuration registers
	localparam int          CFG_IDX_W       = 1;
	localparam logic [7:0]  TARGET_MIN_RST  = 8'd10;
	localparam logic [7:0]  TARGET_MAX_RST  = 8'd220;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_MIN = 1'b0,
		REG_TARGET_MAX = 1'b1
	} cfg_reg_t;

	// Response byte positions
	localparam logic [2:0] POS_HEADER = 3'd0;
	localparam logic [2:0] POS_STATUS = 3'd1;
	localparam logic [2:0] POS_VOLT_H = 3'd2;
	localparam logic [2:0] POS_VOLT_L = 3'd3;
	localparam logic [2:0] POS_CURR_H = 3'd4;
	localparam logic [2:0] POS_CURR_L = 3'd5;
	localparam logic [2:0] POS_CRC_L  = 3'd6;
	localparam logic [2:0] POS_CRC_H  = 3'd7;

	// Job queue between front and back
	localparam int QDEPTH = 2;

	typedef struct packed {
		logic               opcode;
		logic [7:0]         rx_data;
		logic signed [15:0] volt_hundredths;
		logic signed [15:0] curr_hundredths;
		logic               source_running;
	} item_t;

	typedef struct packed {
		logic [7:0] tx_data;
		logic       last_byte;
		logic       watchdog_clear;
		logic       target_write;
		logic [7:0] target_value;
		logic       launch;
		logic       shutdown;
	} result_t;

	// One accepted frame, ready to be answered
	typedef struct packed {
		logic [7:0]  status;
		logic [15:0] volt;
		logic [15:0] curr;
		logic        target_write;
		logic [7:0]  target_value;
		logic        launch;
		logic        shutdown;
	} job_t;

	// Queue status seen by the front
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// File: design/cchu_front.sv
// Front part: frame assembly, CRC check and command decode into a job.
`timescale 1ns / 1ps

module cchu_front import cchu_pkg::*; #(
	parameter int RX_CAPACITY = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  item_t                item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [7:0]           cfg_data,
	output logic                 job_push,
	output job_t                 job
);

	localparam int CNT_W = $clog2(RX_CAPACITY + 1);

	logic [CNT_W-1:0] count_q;
	logic [15:0]      crc_q;
	logic [7:0]       command_q;
	logic [7:0]       argument_q;
	logic [7:0]       target_min_q;
	logic [7:0]       target_max_q;

	logic store;
	logic frame_ok;
	logic launch, shutdown;

	assign store    = accept && !item.opcode && (count_q < CNT_W'(RX_CAPACITY));
	assign frame_ok = (count_q >= CNT_W'(MIN_FRAME)) && (crc_q == 16'h0000);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_min_q <= TARGET_MIN_RST;
			target_max_q <= TARGET_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_TARGET_MIN: target_min_q <= cfg_data;
				REG_TARGET_MAX: target_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Frame count, running CRC and the first two bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			crc_q      <= CRC_INIT;
			command_q  <= '0;
			argument_q <= '0;
		end else if (accept && item.opcode) begin
			count_q <= '0;
			crc_q   <= CRC_INIT;
		end else if (store) begin
			if (count_q == '0) begin
				command_q <= item.rx_data;
			end
			if (count_q == CNT_W'(1)) begin
				argument_q <= item.rx_data;
			end
			crc_q   <= crc_update(crc_q, item.rx_data);
			count_q <= count_q + CNT_W'(1);
		end
	end

	// Command decode; max clamp is checked first
	always_comb begin
		job.target_write = (command_q == CMD_SET_TARGET);
		if (!job.target_write) begin
			job.target_value = 8'h00;
		end else if (argument_q > target_max_q) begin
			job.target_value = target_max_q;
		end else if (argument_q < target_min_q) begin
			job.target_value = target_min_q;
		end else begin
			job.target_value = argument_q;
		end
		launch   = (command_q == CMD_SOURCE) && (argument_q == ARG_LAUNCH);
		shutdown = (command_q == CMD_SOURCE) && (argument_q == ARG_SHUTDOWN);
		job.launch   = launch;
		job.shutdown = shutdown;
		if (launch) begin
			job.status = STATUS_RUNNING;
		end else if (shutdown) begin
			job.status = STATUS_STOPPED;
		end else begin
			job.status = item.source_running ? STATUS_RUNNING : STATUS_STOPPED;
		end
		job.volt = item.volt_hundredths;
		job.curr = item.curr_hundredths;
	end

	assign job_push = accept && item.opcode && frame_ok;

endmodule

// File: design/cchu_queue.sv
// Short job queue between the front and the back.
`timescale 1ns / 1ps

module cchu_queue import cchu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  job_t      wr_job,
	input  logic      rd_en,
	output job_t      rd_job,
	output q_status_t status
);

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	job_t             mem [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_wr, do_rd;

	assign status.full  = (count_q == CNT_W'(QDEPTH));
	assign status.empty = (count_q == '0);
	assign do_wr = wr_en && !status.full;
	assign do_rd = rd_en && !status.empty;

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_job;
		end
	end

	assign rd_job = mem[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(do_wr) - CNT_W'(do_rd);
		end
	end

endmodule

// File: design/cchu_back.sv
// Back part: serializes one job into the eight-byte response with its CRC.
`timescale 1ns / 1ps

module cchu_back import cchu_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    job_valid,
	input  job_t    job,
	output logic    job_pop,
	input  logic    pop,
	output logic    empty,
	output result_t result
);

	logic [2:0]  idx_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	result_t     out_q;

	logic        load;
	logic [7:0]  byte_sel;
	logic [15:0] crc_in;
	logic        first;

	assign load    = job_valid && (!out_valid_q || pop);
	assign job_pop = load && (idx_q == POS_CRC_H);
	assign first   = (idx_q == POS_HEADER);
	assign crc_in  = first ? CRC_INIT : crc_q;

	// Byte for the current position
	always_comb begin
		case (idx_q)
			POS_HEADER: byte_sel = RSP_HEADER;
			POS_STATUS: byte_sel = job.status;
			POS_VOLT_H: byte_sel = job.volt[15:8];
			POS_VOLT_L: byte_sel = job.volt[7:0];
			POS_CURR_H: byte_sel = job.curr[15:8];
			POS_CURR_L: byte_sel = job.curr[7:0];
			POS_CRC_L:  byte_sel = crc_q[7:0];
			POS_CRC_H:  byte_sel = crc_q[15:8];
			default:    byte_sel = 8'h00;
		endcase
	end

	// Position counter, response CRC and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= POS_HEADER;
			crc_q       <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q < POS_CRC_L) begin
					crc_q <= crc_update(crc_in, byte_sel);
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output beat register
	always_ff @(posedge clk) begin
		if (load) begin
			out_q.tx_data        <= byte_sel;
			out_q.last_byte      <= (idx_q == POS_CRC_H);
			out_q.watchdog_clear <= first;
			out_q.target_write   <= first && job.target_write;
			out_q.target_value   <= first ? job.target_value : 8'h00;
			out_q.launch         <= first && job.launch;
			out_q.shutdown       <= first && job.shutdown;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

// File: design/crc_command_frame_handler_unit.sv
// Top level of the CRC-checked command frame handler.
// A good frame's job is queued at its idle beat, then leaves through the back's output register.
// Throughput: one input beat per cycle while full is low; a response streams eight beats
// at one per cycle while pop is held, paced by the back part's output register and the pop side.
// full rises only when the two-entry job queue holds two unanswered frames.
// Reset (arst_n low, asynchronous): frame cleared, CRC 0xFFFF, clamps 10/220, queue and output empty.
`timescale 1ns / 1ps

module crc_command_frame_handler_unit import cchu_pkg::*; #(
	parameter int RX_CAPACITY = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  item_t                item,
	output logic                 empty,
	input  logic                 pop,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [7:0]           cfg_data
);

	logic      accept;
	logic      job_push, job_pop;
	job_t      job_in, job_out;
	q_status_t q_status;

	assign full   = q_status.full;
	assign accept = push && !q_status.full;

	cchu_front #(
		.RX_CAPACITY(RX_CAPACITY)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.job_push (job_push),
		.job      (job_in)
	);

	cchu_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_job (job_in),
		.rd_en  (job_pop),
		.rd_job (job_out),
		.status (q_status)
	);

	cchu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!q_status.empty),
		.job       (job_out),
		.job_pop   (job_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

// File: design/cchu_checker.sv
// Port-level checker for the command frame handler, bound to the top level.
`timescale 1ns / 1ps

module cchu_checker import cchu_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    empty,
	input logic    pop,
	input result_t result
);

	// First beat carries the header byte and is never the last
	a_first_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.watchdog_clear) |-> (result.tx_data == RSP_HEADER && !result.last_byte))
		else $error("first response beat malformed");

	// Command actions only on the first beat, and never launch with shutdown
	a_actions: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.target_write || result.launch || result.shutdown))
			|-> (result.watchdog_clear && !(result.launch && result.shutdown)))
		else $error("command action outside the first beat");

	// A response keeps streaming: a taken beat that is not last is followed by a middle beat
	a_stream: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !result.last_byte) |=> (!empty && !result.watchdog_clear))
		else $error("response run broken");

	// A waiting beat holds while not taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting beat changed");

endmodule

bind crc_command_frame_handler_unit cchu_checker u_cchu_checker (.*);

// File: test/tb.sv
// Self-checking testbench for the CRC-checked command frame handler.
`timescale 1ns / 1ps

module tb;
	import cchu_pkg::*;

	localparam int   RX_CAP       = 20;
	localparam int   RSP_LEN      = 8;
	localparam int   SETTLE       = 16;
	localparam int   LIMIT_CYCLES = 200000;
	localparam logic OP_BYTE      = 1'b0;
	localparam logic OP_IDLE      = 1'b1;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	item_t                item;
	logic                 empty;
	logic                 pop;
	result_t              result;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [7:0]           cfg_data;

	crc_command_frame_handler_unit #(.RX_CAPACITY(RX_CAP)) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data)
	);

	// Shadow of the frame receiver and the clamp registers
	int          rx_count;
	logic [15:0] rx_crc;
	logic [7:0]  rx_cmd;
	logic [7:0]  rx_arg;
	logic [7:0]  clamp_lo;
	logic [7:0]  clamp_hi;

	result_t     reply_q[$];
	logic [7:0]  frame_q[$];

	int  beats_sent;
	int  beats_checked;
	int  replies_due;
	int  clamp_settings;
	int  errors;
	int  cycles;
	bit  gaps_on;
	bit  stalls_on;
	int  stall_left;

	// Clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Watchdog on the whole run
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles, %0d replies outstanding", cycles,
				reply_q.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// CRC-16/CCITT-FALSE, one data bit at a time, msb first
	function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc,
		input logic [7:0] data);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ data[i];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	// Expected reply beats for one accepted input beat
	function automatic void predict_beat(input item_t it);
		int          n;
		logic [15:0] residue;
		logic [15:0] tail_crc;
		logic [7:0]  rsp [RSP_LEN];
		logic [7:0]  tgt;
		logic        set_tgt;
		logic        go;
		logic        stop;
		result_t     r;
		if (it.opcode == OP_BYTE) begin
			if (rx_count < RX_CAP) begin
				if (rx_count == 0) begin
					rx_cmd = it.rx_data;
				end else if (rx_count == 1) begin
					rx_arg = it.rx_data;
				end
				rx_crc = crc_ccitt_step(rx_crc, it.rx_data);
				rx_count++;
			end
			return;
		end
		n = rx_count;
		residue = rx_crc;
		rx_count = 0;
		rx_crc = CRC_INIT;
		if (n < MIN_FRAME || residue != 16'h0000) begin
			return;
		end
		set_tgt = (rx_cmd == CMD_SET_TARGET);
		go = (rx_cmd == CMD_SOURCE) && (rx_arg == ARG_LAUNCH);
		stop = (rx_cmd == CMD_SOURCE) && (rx_arg == ARG_SHUTDOWN);
		// max is checked before min, which matters when the clamps cross
		if (rx_arg > clamp_hi) begin
			tgt = clamp_hi;
		end else if (rx_arg < clamp_lo) begin
			tgt = clamp_lo;
		end else begin
			tgt = rx_arg;
		end
		rsp[0] = RSP_HEADER;
		if (go) begin
			rsp[1] = STATUS_RUNNING;
		end else if (stop) begin
			rsp[1] = STATUS_STOPPED;
		end else begin
			rsp[1] = it.source_running ? STATUS_RUNNING : STATUS_STOPPED;
		end
		rsp[2] = it.volt_hundredths[15:8];
		rsp[3] = it.volt_hundredths[7:0];
		rsp[4] = it.curr_hundredths[15:8];
		rsp[5] = it.curr_hundredths[7:0];
		tail_crc = CRC_INIT;
		for (int k = 0; k < 6; k++) begin
			tail_crc = crc_ccitt_step(tail_crc, rsp[k]);
		end
		rsp[6] = tail_crc[7:0];
		rsp[7] = tail_crc[15:8];
		for (int k = 0; k < RSP_LEN; k++) begin
			r = '0;
			r.tx_data = rsp[k];
			r.last_byte = (k == RSP_LEN - 1);
			if (k == 0) begin
				r.watchdog_clear = 1'b1;
				r.target_write = set_tgt;
				r.target_value = set_tgt ? tgt : 8'h00;
				r.launch = go;
				r.shutdown = stop;
			end
			reply_q.push_back(r);
		end
		replies_due++;
	endfunction

	function automatic string fmt_reply(input result_t r);
		return $sformatf("tx=%h last=%b wdc=%b tw=%b tv=%h launch=%b shut=%b",
			r.tx_data, r.last_byte, r.watchdog_clear, r.target_write, r.target_value,
			r.launch, r.shutdown);
	endfunction

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= 10) begin
			$display("ERROR @%0t: %s", $realtime, msg);
		end
	endtask

	// Reply side: random pop stalls in bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (stall_left > 0) begin
			pop <= 1'b0;
			stall_left--;
		end else if (stalls_on && $urandom_range(0, 9) == 0) begin
			pop <= 1'b0;
			stall_left = $urandom_range(0, 15);
		end else begin
			pop <= 1'b1;
		end
	end

	// Compare every accepted reply beat with the oldest expected one
	always @(posedge clk) begin : check_reply
		result_t want;
		if (arst_n && pop && !empty) begin
			beats_checked++;
			if (reply_q.size() == 0) begin
				flag_error($sformatf("unexpected reply beat: %s", fmt_reply(result)));
			end else begin
				want = reply_q.pop_front();
				if (result.tx_data !== want.tx_data ||
					result.last_byte !== want.last_byte ||
					result.watchdog_clear !== want.watchdog_clear ||
					result.target_write !== want.target_write ||
					result.target_value !== want.target_value ||
					result.launch !== want.launch ||
					result.shutdown !== want.shutdown) begin
					flag_error($sformatf("reply mismatch\n  exp %s\n  got %s",
						fmt_reply(want), fmt_reply(result)));
				end
			end
		end
	end

	// One input beat, with an optional random gap in front
	task automatic send_beat(input item_t it);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		predict_beat(it);
		beats_sent++;
	endtask

	function automatic item_t make_beat(input logic op, input logic [7:0] data,
		input logic [15:0] volt, input logic [15:0] curr, input logic running);
		item_t it;
		it.opcode = op;
		it.rx_data = data;
		it.volt_hundredths = volt;
		it.curr_hundredths = curr;
		it.source_running = running;
		return it;
	endfunction

	// Append the frame CRC, high byte first, so the residue comes out zero
	task automatic seal_frame();
		logic [15:0] c;
		c = CRC_INIT;
		foreach (frame_q[i]) begin
			c = crc_ccitt_step(c, frame_q[i]);
		end
		frame_q.push_back(c[15:8]);
		frame_q.push_back(c[7:0]);
	endtask

	// Stream the bytes of frame_q, then end the frame with a line-idle beat
	task automatic send_frame(input logic [15:0] volt, input logic [15:0] curr,
		input logic running);
		foreach (frame_q[i]) begin
			send_beat(make_beat(OP_BYTE, frame_q[i], 16'($urandom), 16'($urandom),
				1'($urandom)));
		end
		send_beat(make_beat(OP_IDLE, 8'($urandom), volt, curr, running));
	endtask

	task automatic drain_replies();
		push <= 1'b0;
		while (reply_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == REG_TARGET_MIN) begin
			clamp_lo = val;
		end else begin
			clamp_hi = val;
		end
	endtask

	task automatic set_clamps(input logic [7:0] lo, input logic [7:0] hi);
		write_reg(REG_TARGET_MIN, lo);
		write_reg(REG_TARGET_MAX, hi);
		cfg_we <= 1'b0;
		clamp_settings++;
	endtask

	// One random frame: mostly well formed, some broken, short, overlong or noise
	task automatic random_frame();
		int         kind;
		int         len;
		int         pos;
		logic [7:0] cmd;
		logic [7:0] arg;
		kind = $urandom_range(0, 19);
		case ($urandom_range(0, 5))
			0, 1: cmd = CMD_SET_TARGET;
			2, 3: cmd = CMD_SOURCE;
			default: cmd = 8'($urandom);
		endcase
		if (cmd == CMD_SOURCE) begin
			case ($urandom_range(0, 2))
				0: arg = ARG_LAUNCH;
				1: arg = ARG_SHUTDOWN;
				default: arg = 8'($urandom);
			endcase
		end else begin
			case ($urandom_range(0, 6))
				0: arg = clamp_lo;
				1: arg = clamp_hi;
				2: arg = clamp_lo - 8'd1;
				3: arg = clamp_hi + 8'd1;
				4: arg = 8'h00;
				5: arg = 8'hFF;
				default: arg = 8'($urandom);
			endcase
		end
		frame_q.delete();
		frame_q.push_back(cmd);
		frame_q.push_back(arg);
		case (kind)
			// buffer fills exactly with the CRC, trailing bytes are dropped
			12: begin
				while (frame_q.size() < RX_CAP - 2) frame_q.push_back(8'($urandom));
				seal_frame();
				repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
			end
			// CRC lands at least partly past the buffer and is lost
			13: begin
				len = $urandom_range(RX_CAP - 1, RX_CAP + 2);
				while (frame_q.size() < len) frame_q.push_back(8'($urandom));
				seal_frame();
			end
			// two or three bytes with a zero residue: too short to answer
			14: begin
				frame_q.delete();
				if ($urandom_range(0, 1)) begin
					frame_q.push_back(8'($urandom));
				end
				seal_frame();
			end
			// idle with nothing received
			15: frame_q.delete();
			// single bit error somewhere in a good frame
			16, 17: begin
				repeat ($urandom_range(0, 4)) frame_q.push_back(8'($urandom));
				seal_frame();
				pos = $urandom_range(0, frame_q.size() - 1);
				frame_q[pos] = frame_q[pos] ^ (8'h01 << $urandom_range(0, 7));
			end
			// line noise
			18: begin
				frame_q.delete();
				repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom));
			end
			// shortest good frame
			19: seal_frame();
			default: begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, RX_CAP - 4)
					: $urandom_range(0, 4);
				repeat (len) frame_q.push_back(8'($urandom));
				seal_frame();
			end
		endcase
		send_frame(16'($urandom), 16'($urandom), 1'($urandom));
	endtask

	task automatic run_phase(input int beats, input logic [7:0] lo, input logic [7:0] hi);
		int stop_at;
		drain_replies();
		set_clamps(lo, hi);
		stop_at = beats_sent + beats;
		while (beats_sent < stop_at) begin
			random_frame();
		end
	endtask

	// Directed tests
	task automatic test_idle_without_bytes();
		frame_q.delete();
		send_frame(16'h1234, 16'h5678, 1'b1);
	endtask

	task automatic test_short_frame();
		frame_q.delete();
		seal_frame();
		send_frame(16'h0001, 16'h0002, 1'b0);
	endtask

	task automatic test_set_target_clamp();
		frame_q = '{CMD_SET_TARGET, 8'hFF};
		seal_frame();
		send_frame(16'h7FFF, 16'h8000, 1'b0);
	endtask

	task automatic test_source_commands();
		frame_q = '{CMD_SOURCE, ARG_LAUNCH};
		seal_frame();
		send_frame(16'h8000, 16'h7FFF, 1'b0);
		frame_q = '{CMD_SOURCE, ARG_SHUTDOWN};
		seal_frame();
		send_frame(16'hFFFF, 16'h0000, 1'b1);
	endtask

	task automatic test_bad_crc();
		frame_q = '{CMD_SET_TARGET, 8'h00};
		seal_frame();
		frame_q[3] = frame_q[3] ^ 8'h80;
		send_frame(16'h0000, 16'hFFFF, 1'b1);
	endtask

	task automatic test_random_clamps();
		run_phase(60, 8'd0, 8'd255);
		run_phase(60, 8'd255, 8'd0);
		run_phase(60, 8'd100, 8'd100);
		run_phase(60, 8'd200, 8'd40);
		run_phase(60, 8'($urandom), 8'($urandom));
	endtask

	task automatic test_steady_stream();
		drain_replies();
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		run_phase(80, 8'($urandom), 8'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_TARGET_MIN;
		cfg_data = 8'h00;
		rx_count = 0;
		rx_crc = CRC_INIT;
		rx_cmd = 8'h00;
		rx_arg = 8'h00;
		clamp_lo = TARGET_MIN_RST;
		clamp_hi = TARGET_MAX_RST;
		beats_sent = 0;
		beats_checked = 0;
		replies_due = 0;
		clamp_settings = 0;
		errors = 0;
		cycles = 0;
		stall_left = 0;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_without_bytes();
		test_short_frame();
		test_set_target_clamp();
		test_source_commands();
		test_bad_crc();
		test_random_clamps();
		test_steady_stream();
		drain_replies();

		$display("Sent %0d input beats; %0d frames answered, %0d reply beats checked",
			beats_sent, replies_due, beats_checked);
		$display("Clamp settings used: %0d (reset values, wide, crossed, equal, random)",
			clamp_settings);
		if (errors == 0 && reply_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d errors, %0d replies missing", errors, reply_q.size());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: files.f
design/cchu_pkg.sv
design/cchu_front.sv
design/cchu_queue.sv
design/cchu_back.sv
design/crc_command_frame_handler_unit.sv
design/cchu_checker.sv
test/tb.sv
